>>> sv/weighted_increasing_chain_max_top_defines.svh
// Assertion macros for the weighted increasing chain max block
`ifndef WEIGHTED_INCREASING_CHAIN_MAX_TOP_DEFINES_SVH
`define WEIGHTED_INCREASING_CHAIN_MAX_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define WICM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define WICM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wicm_pkg.sv
// Package: constants, types and state codes of the weighted increasing chain max block
`default_nettype none

package wicm_pkg;

  parameter int HEIGHT_COUNT = 1024;
  parameter int HEIGHT_W     = 11;
  parameter int WEIGHT_W     = 32;
  parameter int VAL_W        = 48;

  parameter int LEVELS    = $clog2(HEIGHT_COUNT);
  parameter int LEAF_BASE = 1 << LEVELS;
  parameter int NODE_W    = LEVELS + 1;
  parameter int NODES     = 1 << NODE_W;
  parameter int TOP_W     = NODE_W + 1;
  parameter int HI_W      = LEVELS + 1;
  parameter int LVL_W     = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_DRAIN,
    ST_ADD,
    ST_UPDATE,
    ST_WB,
    ST_DONE
  } wicm_state_e;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [NODE_W-1:0] raddr;
  } tree_req_t;

endpackage

`default_nettype wire

>>> sv/wicm_in_if.sv
// Input channel interface: height and weight of one request
`default_nettype none

interface wicm_in_if;
  logic                         valid;
  logic                         ready;
  logic [wicm_pkg::HEIGHT_W-1:0] height;
  logic [wicm_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, output height, output weight, input ready);
  modport sink   (input valid, input height, input weight, output ready);
endinterface

`default_nettype wire

>>> sv/wicm_out_if.sv
// Output channel interface: chain value and running best of one result
`default_nettype none

interface wicm_out_if;
  logic                      valid;
  logic                      ready;
  logic [wicm_pkg::VAL_W-1:0] chain_value;
  logic [wicm_pkg::VAL_W-1:0] best_so_far;

  modport source (output valid, output chain_value, output best_so_far, input ready);
  modport sink   (input valid, input chain_value, input best_so_far, output ready);
endinterface

`default_nettype wire

>>> sv/wicm_tree_ram.sv
// Range-maximum tree storage: one write port, one read port with registered data
`default_nettype none

module wicm_tree_ram (
  input  logic                         clk_i,
  input  wicm_pkg::tree_req_t          req_i,
  output logic [wicm_pkg::VAL_W-1:0]   rdata_o
);

  logic [wicm_pkg::VAL_W-1:0] mem [wicm_pkg::NODES];
  logic [wicm_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/weighted_increasing_chain_max_top.sv
// Top level: weighted increasing chain max over a range-maximum tree in memory
//
//   channel  dir  fields                      handshake
//   req_i    in   height[10:0] weight[31:0]   valid/ready
//   res_o    out  chain_value, best_so_far    valid/ready (registered)
//
// One request at a time. Each request makes LEVELS+1 reads through the tree
// memory's single read port for the prefix maximum; when the tree is raised
// it then makes LEVELS+1 read-modify-writes up the leaf-to-root path, and
// when it is not (height zero or above HEIGHT_COUNT) it skips them.
// After reset a clearing pass writes all NODES entries before the first
// request is taken.
// A stalled result sits in the output register; the next request is
// accepted meanwhile and waits for the register to drain only at its end.
`default_nettype none

`include "weighted_increasing_chain_max_top_defines.svh"

module weighted_increasing_chain_max_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  wicm_in_if.sink     req_i,
  wicm_out_if.source  res_o
);

  localparam int NW = wicm_pkg::NODE_W;
  localparam int VW = wicm_pkg::VAL_W;
  localparam int TW = wicm_pkg::TOP_W;
  localparam int HW = wicm_pkg::HEIGHT_W;
  localparam int LW = wicm_pkg::LVL_W;

  wicm_pkg::wicm_state_e state_q, state_d;
  wicm_pkg::tree_req_t   tree_req;

  logic [NW-1:0] clr_q, clr_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic          take_q, take_d;
  logic          wr_pend_q, wr_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] best_q, best_d;

  logic [TW-1:0] top_q, top_d;
  logic [NW-1:0] node_q, node_d;
  logic [NW-1:0] wnode_q, wnode_d;
  logic [VW-1:0] acc_q, acc_d;
  logic [VW-1:0] chain_q, chain_d;
  logic [wicm_pkg::WEIGHT_W-1:0] weight_q, weight_d;
  logic          upd_q, upd_d;
  logic [VW-1:0] out_chain_q, out_chain_d;
  logic [VW-1:0] out_best_q, out_best_d;

  logic [VW-1:0] rd_data;
  logic [VW-1:0] op_a, op_b, mx;
  logic [VW:0]   sum;
  logic [HW-1:0] hm1;
  logic          h_zero, in_range;
  logic [wicm_pkg::HI_W-1:0] hi;

  wicm_tree_ram u_tree_ram (
    .clk_i   (clk_i),
    .req_i   (tree_req),
    .rdata_o (rd_data)
  );

  // shared max unit
  assign op_a = (state_q == wicm_pkg::ST_DONE) ? best_q : rd_data;
  assign op_b = (state_q == wicm_pkg::ST_QUERY || state_q == wicm_pkg::ST_DRAIN) ?
                acc_q : chain_q;
  assign mx   = (op_a > op_b) ? op_a : op_b;

  assign sum = {1'b0, acc_q} + (VW + 1)'(weight_q);

  assign hm1      = req_i.height - HW'(1);
  assign h_zero   = (req_i.height == '0);
  assign in_range = !h_zero && (32'(hm1) < 32'(wicm_pkg::HEIGHT_COUNT));

  always_comb begin
    if (h_zero) begin
      hi = '0;
    end else if (in_range) begin
      hi = wicm_pkg::HI_W'(hm1);
    end else begin
      hi = wicm_pkg::HI_W'(wicm_pkg::HEIGHT_COUNT);
    end
  end

  assign req_i.ready       = (state_q == wicm_pkg::ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.chain_value = out_chain_q;
  assign res_o.best_so_far = out_best_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    take_d      = 1'b0;
    wr_pend_d   = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    best_d      = best_q;
    top_d       = top_q;
    node_d      = node_q;
    wnode_d     = wnode_q;
    acc_d       = take_q ? mx : acc_q;
    chain_d     = chain_q;
    weight_d    = weight_q;
    upd_d       = upd_q;
    out_chain_d = out_chain_q;
    out_best_d  = out_best_q;

    tree_req.we    = wr_pend_q;
    tree_req.waddr = wnode_q;
    tree_req.wdata = mx;
    tree_req.raddr = '0;

    unique case (state_q)
      wicm_pkg::ST_CLEAR: begin
        tree_req.we    = 1'b1;
        tree_req.waddr = clr_q;
        tree_req.wdata = '0;
        clr_d          = clr_q + NW'(1);
        if (&clr_q) begin
          state_d = wicm_pkg::ST_IDLE;
        end
      end
      wicm_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          top_d    = TW'(wicm_pkg::LEAF_BASE) + TW'(hi);
          node_d   = NW'(wicm_pkg::LEAF_BASE) + NW'(hm1);
          upd_d    = in_range;
          weight_d = req_i.weight;
          acc_d    = '0;
          lvl_d    = '0;
          state_d  = wicm_pkg::ST_QUERY;
        end
      end
      wicm_pkg::ST_QUERY: begin
        if (lvl_q == LW'(wicm_pkg::LEVELS)) begin
          // top level: only the full range takes the root
          tree_req.raddr = NW'(1);
          take_d         = top_q[1];
          lvl_d          = '0;
          state_d        = wicm_pkg::ST_DRAIN;
        end else begin
          tree_req.raddr = NW'(top_q - TW'(1));
          take_d         = top_q[0];
          top_d          = top_q >> 1;
          lvl_d          = lvl_q + LW'(1);
        end
      end
      wicm_pkg::ST_DRAIN: begin
        state_d = wicm_pkg::ST_ADD;
      end
      wicm_pkg::ST_ADD: begin
        chain_d = sum[VW] ? '1 : sum[VW-1:0];
        lvl_d   = '0;
        state_d = upd_q ? wicm_pkg::ST_UPDATE : wicm_pkg::ST_DONE;
      end
      wicm_pkg::ST_UPDATE: begin
        tree_req.raddr = node_q;
        wr_pend_d      = 1'b1;
        wnode_d        = node_q;
        node_d         = node_q >> 1;
        if (lvl_q == LW'(wicm_pkg::LEVELS)) begin
          lvl_d   = '0;
          state_d = wicm_pkg::ST_WB;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      wicm_pkg::ST_WB: begin
        state_d = wicm_pkg::ST_DONE;
      end
      wicm_pkg::ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_chain_d = chain_q;
          out_best_d  = mx;
          best_d      = mx;
          state_d     = wicm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wicm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wicm_pkg::ST_CLEAR;
      clr_q       <= '0;
      lvl_q       <= '0;
      take_q      <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      best_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lvl_q       <= lvl_d;
      take_q      <= take_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      best_q      <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    node_q      <= node_d;
    wnode_q     <= wnode_d;
    acc_q       <= acc_d;
    chain_q     <= chain_d;
    weight_q    <= weight_d;
    upd_q       <= upd_d;
    out_chain_q <= out_chain_d;
    out_best_q  <= out_best_d;
  end

  `WICM_ASSERT_IMP(a_no_write_in_query, state_q == wicm_pkg::ST_QUERY, !tree_req.we, "tree write during query")
  `WICM_ASSERT_NXT(a_best_monotonic, 1'b1, best_q >= $past(best_q), "running best decreased")
  `WICM_ASSERT_IMP(a_best_covers_chain, out_valid_q, out_best_q >= out_chain_q, "best below chain value")
  `WICM_ASSERT_IMP(a_clear_full_pass, (state_q == wicm_pkg::ST_CLEAR) && (state_d == wicm_pkg::ST_IDLE), &clr_q, "clear pass ended early")

endmodule

`default_nettype wire
